>>> src/bre_pkg.sv
// Package for the bitmap range engine: codes, controller states and interface structs.
`default_nettype none
package bre_pkg;

    localparam logic [1:0] MODE_FILL  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_COUNT = 2'd2;
    localparam logic [1:0] MODE_FIND  = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RANGE_ERR = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PROC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic launch;
        logic proc;
        logic adv;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic range_err;
        logic at_end;
        logic hit;
    } sts_t;

endpackage
`default_nettype wire

>>> src/bre_datapath.sv
// Datapath of the bitmap range engine: word store, range masks, count and search logic.
`default_nettype none
module bre_datapath #(
    parameter int CAPACITY_BITS = 4096
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bre_pkg::cmd_t cmd,
    output bre_pkg::sts_t      sts,
    input  wire logic [1:0]    mode,
    input  wire logic [11:0]   first_bit,
    input  wire logic [11:0]   last_bit,
    input  wire logic          bit_value,
    output logic               done,
    output logic [1:0]         status,
    output logic [12:0]        result_value,
    output logic [12:0]        bits_in_use
);

    localparam int WORDS = (CAPACITY_BITS + 63) / 64;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IW    = $clog2(WORDS + 1);

    logic [63:0]   mem [WORDS];
    logic [63:0]   rdata_reg;

    logic [1:0]    mode_reg;
    logic [11:0]   first_reg;
    logic [11:0]   last_reg;
    logic          val_reg;
    logic [5:0]    cur_w_reg;
    logic [IW-1:0] init_reg;
    logic [12:0]   used_reg;
    logic [12:0]   acc_reg;
    logic          done_reg;
    logic [1:0]    status_reg;
    logic [12:0]   result_reg;

    logic [5:0]    fw;
    logic [5:0]    lw;
    logic [5:0]    start_w;
    logic [5:0]    end_w;
    logic          word_ok;
    logic [63:0]   eff;
    logic [63:0]   lo_mask;
    logic [63:0]   hi_mask;
    logic [63:0]   rmask;
    logic [63:0]   new_word;
    logic [63:0]   target;
    logic [6:0]    word_ones;
    logic [12:0]   acc_next;
    logic [5:0]    ffs;
    logic          range_err;
    logic          we;
    logic [AW-1:0] raddr;

    assign fw = first_reg[11:6];
    assign lw = last_reg[11:6];

    always_comb
    begin
        case (mode_reg)
            bre_pkg::MODE_FILL:
            begin
                range_err = (first_reg > last_reg) || (32'(last_reg) >= CAPACITY_BITS);
            end
            bre_pkg::MODE_READ:
            begin
                range_err = (32'(first_reg) >= CAPACITY_BITS);
            end
            default:
            begin
                range_err = (first_reg > last_reg) || ({1'b0, last_reg} >= used_reg);
            end
        endcase
    end

    // A fill that lands above the initialized words first sweeps the gap with zeros.
    assign start_w = (mode_reg == bre_pkg::MODE_FILL && 32'(fw) > 32'(init_reg))
                     ? 6'(init_reg) : fw;
    assign end_w   = (mode_reg == bre_pkg::MODE_READ) ? fw : lw;

    // Words never written read as zero; written words hold zeros above the used size.
    assign word_ok = 32'(cur_w_reg) < 32'(init_reg);
    assign eff     = word_ok ? rdata_reg : 64'd0;

    assign lo_mask = (cur_w_reg > fw) ? {64{1'b1}} :
                     (cur_w_reg == fw) ? ({64{1'b1}} << first_reg[5:0]) : 64'd0;
    assign hi_mask = (cur_w_reg < lw) ? {64{1'b1}} :
                     (cur_w_reg == lw) ? ({64{1'b1}} >> (6'd63 - last_reg[5:0])) : 64'd0;
    assign rmask   = lo_mask & hi_mask;

    assign new_word  = (eff & ~rmask) | (val_reg ? rmask : 64'd0);
    assign word_ones = 7'($countones(eff & rmask));
    assign acc_next  = acc_reg + 13'(word_ones);
    assign target    = (val_reg ? eff : ~eff) & rmask;

    always_comb
    begin
        ffs = 6'd0;
        for (int i = 63; i >= 0; i--)
        begin
            if (target[i])
            begin
                ffs = 6'(i);
            end
        end
    end

    assign sts.range_err = range_err;
    assign sts.at_end    = (cur_w_reg == end_w);
    assign sts.hit       = (mode_reg == bre_pkg::MODE_FIND) && (|target);

    assign we    = cmd.proc && (mode_reg == bre_pkg::MODE_FILL);
    assign raddr = cmd.launch ? AW'(start_w) : AW'(cur_w_reg + 6'd1);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[AW'(cur_w_reg)] <= new_word;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode;
            first_reg <= first_bit;
            last_reg  <= last_bit;
            val_reg   <= bit_value;
        end
        if (cmd.launch)
        begin
            cur_w_reg <= start_w;
            acc_reg   <= 13'd0;
        end
        else if (cmd.adv)
        begin
            cur_w_reg <= cur_w_reg + 6'd1;
            acc_reg   <= acc_next;
        end
        if (cmd.finish)
        begin
            status_reg <= bre_pkg::STATUS_OK;
            result_reg <= 13'd0;
            if (range_err)
            begin
                status_reg <= bre_pkg::STATUS_RANGE_ERR;
            end
            else
            begin
                case (mode_reg)
                    bre_pkg::MODE_READ:
                    begin
                        result_reg <= {12'd0, eff[first_reg[5:0]]};
                    end
                    bre_pkg::MODE_COUNT:
                    begin
                        result_reg <= acc_next;
                    end
                    bre_pkg::MODE_FIND:
                    begin
                        if (sts.hit)
                        begin
                            result_reg <= {1'b0, cur_w_reg, ffs};
                        end
                        else
                        begin
                            status_reg <= bre_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        result_reg <= 13'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            used_reg <= 13'd0;
            init_reg <= '0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.finish && !range_err)
            begin
                if (mode_reg == bre_pkg::MODE_FILL)
                begin
                    if ({1'b0, last_reg} + 13'd1 > used_reg)
                    begin
                        used_reg <= {1'b0, last_reg} + 13'd1;
                    end
                    if (32'(lw) + 1 > 32'(init_reg))
                    begin
                        init_reg <= IW'(32'(lw) + 1);
                    end
                end
                else if (mode_reg == bre_pkg::MODE_READ)
                begin
                    if ({1'b0, first_reg} + 13'd1 > used_reg)
                    begin
                        used_reg <= {1'b0, first_reg} + 13'd1;
                    end
                end
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign result_value = result_reg;
    assign bits_in_use  = used_reg;

endmodule
`default_nettype wire

>>> src/bre_ctrl.sv
// Controller of the bitmap range engine: sequences check and word walk.
`default_nettype none
module bre_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output bre_pkg::cmd_t      cmd,
    input  wire bre_pkg::sts_t sts
);

    bre_pkg::state_t state_reg;
    bre_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bre_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            bre_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = bre_pkg::ST_CHECK;
                end
            end
            bre_pkg::ST_CHECK:
            begin
                if (sts.range_err)
                begin
                    cmd.finish = 1'b1;
                    state_next = bre_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.launch = 1'b1;
                    state_next = bre_pkg::ST_PROC;
                end
            end
            bre_pkg::ST_PROC:
            begin
                cmd.proc = 1'b1;
                if (sts.at_end || sts.hit)
                begin
                    cmd.finish = 1'b1;
                    state_next = bre_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.adv = 1'b1;
                end
            end
            default:
            begin
                state_next = bre_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != bre_pkg::ST_IDLE);

endmodule
`default_nettype wire

>>> src/bitmap_range_engine.sv
// Top level of the bitmap range engine: controller and datapath joined by command and status.
//
//   Channel   Signals                                    Handshake
//   -------   ----------------------------------------   -------------------------
//   command   mode, first_bit, last_bit, bit_value       start high, busy low
//   result    status, result_value, bits_in_use          done high for one cycle
//
// An item is captured, its range is checked, and then the operation walks the 64-bit
// words it covers in turn; the word memory is read one word per cycle. A find stops
// at the word holding the first match, and a range error finishes after the check
// cycle. Results appear with done in the cycle after the last step. Reset clears the
// used size and the initialized-word count, so no clearing pass over the memory is
// needed. The receiver cannot stall the block.
`default_nettype none
module bitmap_range_engine #(
    parameter int CAPACITY_BITS = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [11:0] first_bit,
    input  wire logic [11:0] last_bit,
    input  wire logic        bit_value,
    output logic             done,
    output logic [1:0]       status,
    output logic [12:0]      result_value,
    output logic [12:0]      bits_in_use
);

    bre_pkg::cmd_t cmd;
    bre_pkg::sts_t sts;

    // The controller walks the words; the datapath holds the store and does the math.
    bre_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    bre_datapath #(
        .CAPACITY_BITS (CAPACITY_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .first_bit    (first_bit),
        .last_bit     (last_bit),
        .bit_value    (bit_value),
        .done         (done),
        .status       (status),
        .result_value (result_value),
        .bits_in_use  (bits_in_use)
    );

`ifndef SYNTHESIS
    // An accepted item always occupies the engine in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the engine busy");

    // A result never carries an undefined status code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == bre_pkg::STATUS_OK || status == bre_pkg::STATUS_RANGE_ERR ||
                  status == bre_pkg::STATUS_NOT_FOUND))
        else $error("result carries an undefined status code");

    // Error and miss results carry a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != bre_pkg::STATUS_OK) |-> (result_value == 13'd0))
        else $error("error result carries a nonzero value");

    // A result is produced only as an item finishes, never while idle before it.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a busy item");
`endif

endmodule
`default_nettype wire
